### src/fsba_pkg.sv
// Shared types and constants for the fair-share bucket arbiter.
package fsba_pkg;

    localparam int NUM_BUCKETS_DEF = 8;
    localparam int EXCESS_BITS_DEF = 48;
    localparam int MASK_BITS       = 8;
    localparam int BKT_W           = 3;
    localparam int ELAPSED_BITS    = 32;
    localparam int STATUS_W        = 3;

    typedef enum logic {
        OP_BEGIN = 1'b0,
        OP_END   = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 3'd0,
        ST_ALL_EMPTY   = 3'd1,
        ST_END_CHARGED = 3'd2,
        ST_END_IGNORED = 3'd3,
        ST_BEGIN_BUSY  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_CHARGE_RD,
        S_CHARGE_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                    opcode;
        logic [MASK_BITS-1:0]    pending_mask;
        logic [ELAPSED_BITS-1:0] elapsed;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BKT_W-1:0]    granted_bucket;
    } out_item_t;

endpackage

### src/fair_share_bucket_arbiter.sv
// Fair-share bucket arbiter: least-excess grant with per-bucket excess memory.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  s_      | in        | s_valid / s_ready  | s_item: opcode, pending_mask, elapsed
//  m_      | out       | m_valid / m_ready  | m_item: status, granted_bucket
//
// Begin with a grant free: scan reads min(NUM_BUCKETS,8) entries, update writes all
// NUM_BUCKETS (skipped if none is pending), then the result loads. Other items go
// straight to it, an end with grant via a charge read and write. The excess memory
// (one read, one write per cycle) sets their pace. One item is in flight at a time;
// the result register lets the next request enter while a result waits on m_ready.
// aresetn clears control state and the per-entry valid bits; no clearing pass.

module fair_share_bucket_arbiter #(
    parameter int NUM_BUCKETS = fsba_pkg::NUM_BUCKETS_DEF,
    parameter int EXCESS_BITS = fsba_pkg::EXCESS_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fsba_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output fsba_pkg::out_item_t m_item
);

    localparam int ADDR_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
    localparam int SCAN_N = (NUM_BUCKETS < fsba_pkg::MASK_BITS) ?
                            NUM_BUCKETS : fsba_pkg::MASK_BITS;
    localparam logic [EXCESS_BITS-1:0] EXCESS_MAX = '1;

    // excess memory, one read and one write port, registered read data
    logic [EXCESS_BITS-1:0] mem [NUM_BUCKETS];
    logic [EXCESS_BITS-1:0] mem_rdata_reg;
    logic                   rd_vbit_reg;
    logic [NUM_BUCKETS-1:0] valid_reg;
    logic                   mem_re, mem_we;
    logic [ADDR_W-1:0]      mem_raddr, mem_waddr;
    logic [EXCESS_BITS-1:0] mem_wdata;

    fsba_pkg::state_t  state_reg, state_next;
    fsba_pkg::status_t status_reg, status_next;
    logic [fsba_pkg::BKT_W-1:0] bucket_reg, bucket_next;

    logic [fsba_pkg::MASK_BITS-1:0]    mask_sh_reg, mask_sh_next;
    logic [fsba_pkg::ELAPSED_BITS-1:0] elapsed_reg, elapsed_next;
    logic [CNT_W-1:0]                  idx_reg, idx_next;
    logic                              rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0]                 rd_addr_reg, rd_addr_next;
    logic                              found_reg, found_next;
    logic [EXCESS_BITS-1:0]            best_val_reg, best_val_next;
    logic [fsba_pkg::BKT_W-1:0]        best_idx_reg, best_idx_next;
    logic                              grant_held_reg, grant_held_next;
    logic [fsba_pkg::BKT_W-1:0]        grant_idx_reg, grant_idx_next;
    logic                              m_valid_reg, m_valid_next;
    fsba_pkg::out_item_t               m_item_reg;

    logic                   in_fire, out_load;
    logic                   scan_left, upd_left, scan_done, upd_done;
    logic [EXCESS_BITS-1:0] rd_data;
    logic [EXCESS_BITS:0]   diff, sum;
    logic [EXCESS_BITS-1:0] sub_clamped, add_sat;

    assign s_ready  = (state_reg == fsba_pkg::S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_load = (state_reg == fsba_pkg::S_DONE) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    assign scan_left = idx_reg < CNT_W'(SCAN_N);
    assign upd_left  = idx_reg < CNT_W'(NUM_BUCKETS);
    assign scan_done = !scan_left && !rd_pend_reg;
    assign upd_done  = !upd_left && !rd_pend_reg;

    // never-written entries read as zero
    assign rd_data     = rd_vbit_reg ? mem_rdata_reg : '0;
    assign diff        = {1'b0, rd_data} - {1'b0, best_val_reg};
    assign sub_clamped = diff[EXCESS_BITS] ? '0 : diff[EXCESS_BITS-1:0];
    assign sum         = {1'b0, rd_data} + (EXCESS_BITS+1)'(elapsed_reg);
    assign add_sat     = sum[EXCESS_BITS] ? EXCESS_MAX : sum[EXCESS_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
            rd_vbit_reg   <= valid_reg[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[mem_waddr] <= 1'b1;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fsba_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (s_item.opcode == fsba_pkg::OP_BEGIN) begin
                        state_next = grant_held_reg ? fsba_pkg::S_DONE : fsba_pkg::S_SCAN;
                    end else begin
                        state_next = grant_held_reg ? fsba_pkg::S_CHARGE_RD : fsba_pkg::S_DONE;
                    end
                end
            end
            fsba_pkg::S_SCAN: begin
                if (scan_done) begin
                    state_next = found_reg ? fsba_pkg::S_UPDATE : fsba_pkg::S_DONE;
                end
            end
            fsba_pkg::S_UPDATE: begin
                if (upd_done) begin
                    state_next = fsba_pkg::S_DONE;
                end
            end
            fsba_pkg::S_CHARGE_RD: state_next = fsba_pkg::S_CHARGE_WR;
            fsba_pkg::S_CHARGE_WR: state_next = fsba_pkg::S_DONE;
            fsba_pkg::S_DONE: begin
                if (out_load) begin
                    state_next = fsba_pkg::S_IDLE;
                end
            end
            default: state_next = fsba_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        status_next     = status_reg;
        bucket_next     = bucket_reg;
        mask_sh_next    = mask_sh_reg;
        elapsed_next    = elapsed_reg;
        idx_next        = idx_reg;
        rd_pend_next    = 1'b0;
        rd_addr_next    = rd_addr_reg;
        found_next      = found_reg;
        best_val_next   = best_val_reg;
        best_idx_next   = best_idx_reg;
        grant_held_next = grant_held_reg;
        grant_idx_next  = grant_idx_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_raddr       = idx_reg[ADDR_W-1:0];
        mem_waddr       = rd_addr_reg;
        mem_wdata       = sub_clamped;
        m_valid_next    = out_load || (m_valid_reg && !m_ready);

        case (state_reg)
            fsba_pkg::S_IDLE: begin
                if (in_fire) begin
                    mask_sh_next = s_item.pending_mask;
                    elapsed_next = s_item.elapsed;
                    idx_next     = '0;
                    found_next   = 1'b0;
                    bucket_next  = '0;
                    if (s_item.opcode == fsba_pkg::OP_BEGIN) begin
                        status_next = fsba_pkg::ST_BEGIN_BUSY;
                    end else begin
                        status_next = fsba_pkg::ST_END_IGNORED;
                    end
                end
            end
            fsba_pkg::S_SCAN: begin
                if (scan_left) begin
                    mem_re       = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_addr_next = idx_reg[ADDR_W-1:0];
                end
                if (rd_pend_reg) begin
                    mask_sh_next = mask_sh_reg >> 1;
                    // strict less-than keeps the lowest index on a tie
                    if (mask_sh_reg[0] && (!found_reg || rd_data < best_val_reg)) begin
                        found_next    = 1'b1;
                        best_val_next = rd_data;
                        best_idx_next = fsba_pkg::BKT_W'(rd_addr_reg);
                    end
                end
                if (scan_done) begin
                    idx_next    = '0;
                    status_next = found_reg ? fsba_pkg::ST_GRANTED : fsba_pkg::ST_ALL_EMPTY;
                    bucket_next = found_reg ? best_idx_reg : '0;
                end
            end
            fsba_pkg::S_UPDATE: begin
                // read entry i while writing back entry i-1
                if (upd_left) begin
                    mem_re       = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_addr_next = idx_reg[ADDR_W-1:0];
                end
                if (rd_pend_reg) begin
                    mem_we = 1'b1;
                end
                if (upd_done) begin
                    grant_held_next = 1'b1;
                    grant_idx_next  = best_idx_reg;
                end
            end
            fsba_pkg::S_CHARGE_RD: begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(grant_idx_reg);
            end
            fsba_pkg::S_CHARGE_WR: begin
                mem_we          = 1'b1;
                mem_waddr       = ADDR_W'(grant_idx_reg);
                mem_wdata       = add_sat;
                grant_held_next = 1'b0;
                status_next     = fsba_pkg::ST_END_CHARGED;
                bucket_next     = grant_idx_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= fsba_pkg::S_IDLE;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            grant_held_reg <= 1'b0;
            grant_idx_reg  <= '0;
            m_valid_reg    <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            rd_pend_reg    <= rd_pend_next;
            found_reg      <= found_next;
            grant_held_reg <= grant_held_next;
            grant_idx_reg  <= grant_idx_next;
            m_valid_reg    <= m_valid_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        bucket_reg   <= bucket_next;
        mask_sh_reg  <= mask_sh_next;
        elapsed_reg  <= elapsed_next;
        rd_addr_reg  <= rd_addr_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        if (out_load) begin
            m_item_reg.status         <= status_reg;
            m_item_reg.granted_bucket <= bucket_reg;
        end
    end

`ifndef SYNTH
    a_no_same_addr_rw: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same excess entry in one cycle");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == fsba_pkg::S_UPDATE || state_reg == fsba_pkg::S_CHARGE_WR))
        else $error("excess memory written outside update or charge");

    a_grant_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(grant_held_reg) |-> $past(state_reg == fsba_pkg::S_UPDATE))
        else $error("grant taken without an update pass");

    a_granted_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && status_reg == fsba_pkg::ST_GRANTED)
            |-> (int'(bucket_reg) < NUM_BUCKETS) && grant_held_reg)
        else $error("granted bucket out of range or grant not held");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for the fair-share bucket arbiter: grant prediction and response checks.
`timescale 1ns / 1ps

class grant_ledger;
    // predicted arbiter state
    logic [fsba_pkg::EXCESS_BITS_DEF-1:0] bucket_excess [fsba_pkg::NUM_BUCKETS_DEF];
    logic                                 grant_live;
    logic [fsba_pkg::BKT_W-1:0]           grant_slot;
    fsba_pkg::out_item_t                  awaiting [$];
    int                                   err_count;
    int                                   status_seen [5];

    function new();
        int b;
        for (b = 0; b < fsba_pkg::NUM_BUCKETS_DEF; b++) bucket_excess[b] = '0;
        grant_live = 1'b0;
        grant_slot = '0;
        err_count  = 0;
        for (b = 0; b < 5; b++) status_seen[b] = 0;
    endfunction

    function fsba_pkg::out_item_t predict_response(fsba_pkg::in_item_t req);
        fsba_pkg::out_item_t                  rsp;
        logic [fsba_pkg::EXCESS_BITS_DEF-1:0] floor_val;
        logic [fsba_pkg::EXCESS_BITS_DEF:0]   sum;
        bit                                   found;
        int                                   pick;
        int                                   b;
        rsp       = '0;
        floor_val = '0;
        found     = 1'b0;
        pick      = 0;
        if (req.opcode == fsba_pkg::OP_BEGIN) begin
            if (grant_live) begin
                rsp.status = fsba_pkg::ST_BEGIN_BUSY;
            end else begin
                // least excess wins, strict compare keeps the lowest index on a tie
                for (b = 0; b < fsba_pkg::NUM_BUCKETS_DEF && b < fsba_pkg::MASK_BITS; b++) begin
                    if (req.pending_mask[b] && (!found || bucket_excess[b] < floor_val)) begin
                        found     = 1'b1;
                        pick      = b;
                        floor_val = bucket_excess[b];
                    end
                end
                if (!found) begin
                    rsp.status = fsba_pkg::ST_ALL_EMPTY;
                end else begin
                    for (b = 0; b < fsba_pkg::NUM_BUCKETS_DEF; b++)
                        bucket_excess[b] = (bucket_excess[b] > floor_val) ?
                                           bucket_excess[b] - floor_val : '0;
                    grant_live         = 1'b1;
                    grant_slot         = pick[fsba_pkg::BKT_W-1:0];
                    rsp.status         = fsba_pkg::ST_GRANTED;
                    rsp.granted_bucket = pick[fsba_pkg::BKT_W-1:0];
                end
            end
        end else begin
            if (!grant_live) begin
                rsp.status = fsba_pkg::ST_END_IGNORED;
            end else begin
                sum = {1'b0, bucket_excess[grant_slot]} + req.elapsed;
                bucket_excess[grant_slot] = sum[fsba_pkg::EXCESS_BITS_DEF] ? '1 :
                                            sum[fsba_pkg::EXCESS_BITS_DEF-1:0];
                grant_live         = 1'b0;
                rsp.status         = fsba_pkg::ST_END_CHARGED;
                rsp.granted_bucket = grant_slot;
            end
        end
        return rsp;
    endfunction

    function void log_request(fsba_pkg::in_item_t req);
        fsba_pkg::out_item_t rsp;
        rsp = predict_response(req);
        status_seen[rsp.status]++;
        awaiting.push_back(rsp);
    endfunction

    function void match_response(fsba_pkg::out_item_t got);
        fsba_pkg::out_item_t want;
        if (awaiting.size() == 0) begin
            $error("unexpected response: status %0d bucket %0d",
                   got.status, got.granted_bucket);
            err_count++;
            return;
        end
        want = awaiting.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
        end
        if (got.granted_bucket !== want.granted_bucket) begin
            $error("granted_bucket: expected %0d, got %0d",
                   want.granted_bucket, got.granted_bucket);
            err_count++;
        end
    endfunction
endclass

module tb_top;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    fsba_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    fsba_pkg::out_item_t m_item;

    grant_ledger ledger = new();
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          req_total     = 0;

    fair_share_bucket_arbiter DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) ledger.match_response(m_item);
    end

    task automatic send_request(input fsba_pkg::in_item_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_item  = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        ledger.log_request(req);
        req_total++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (ledger.awaiting.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [fsba_pkg::MASK_BITS-1:0] pick_mask();
        logic [31:0] r;
        case ($urandom_range(3))
            0:       r = $urandom;
            1:       r = 32'h1 << $urandom_range(7);
            2:       r = 32'hFF;
            default: r = $urandom & $urandom;
        endcase
        return r[fsba_pkg::MASK_BITS-1:0];
    endfunction

    // unused fields carry random bits so the block must ignore them
    function automatic fsba_pkg::in_item_t begin_req(logic [fsba_pkg::MASK_BITS-1:0] mask);
        fsba_pkg::in_item_t req;
        req.opcode       = fsba_pkg::OP_BEGIN;
        req.pending_mask = mask;
        req.elapsed      = $urandom;
        return req;
    endfunction

    function automatic fsba_pkg::in_item_t end_req(logic [fsba_pkg::ELAPSED_BITS-1:0] elapsed);
        fsba_pkg::in_item_t req;
        req.opcode       = fsba_pkg::OP_END;
        req.pending_mask = pick_mask();
        req.elapsed      = elapsed;
        return req;
    endfunction

    // small values keep ties common, large ones stress the compare
    function automatic logic [fsba_pkg::ELAPSED_BITS-1:0] pick_elapsed();
        case ($urandom_range(4))
            0:       return $urandom_range(3);
            1:       return $urandom_range(255);
            2:       return $urandom;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom_range(65535) << $urandom_range(16);
        endcase
    endfunction

    int send_phase  [4] = '{0, 82, 0, 38};
    int stall_phase [4] = '{0, 0, 82, 38};

    initial begin
        int ph;
        int made;
        fsba_pkg::in_item_t noise;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: ignored end, empty mask, ties, busy begin, extremes of elapsed
        send_request(end_req(32'h0));
        send_request(begin_req(8'h00));
        send_request(begin_req(8'hFF));
        send_request(begin_req(8'h01));
        send_request(end_req(32'hFFFF_FFFF));
        send_request(end_req(32'h1234_5678));
        send_request(begin_req(8'h80));
        send_request(end_req(32'h1));
        send_request(begin_req(8'h81));
        send_request(end_req(32'h0));
        send_request(begin_req(8'h01));
        send_request(end_req(32'h8000_0000));
        send_request(begin_req(8'h55));
        send_request(end_req(32'h0000_FFFF));
        send_request(begin_req(8'hAA));
        send_request(end_req(32'h7FFF_FFFF));
        send_request(begin_req(8'h00));
        send_request(begin_req(8'hFE));
        send_request(begin_req(8'h00));
        send_request(end_req(32'h5));
        send_request(begin_req(8'hFF));
        send_request(end_req(32'hFFFF_FFFE));
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_phase[ph];
            stall_pct     = stall_phase[ph];
            made          = 0;
            while (made < 420) begin
                if ($urandom_range(99) < 85) begin
                    send_request(begin_req(pick_mask()));
                    send_request(end_req(pick_elapsed()));
                    made += 2;
                end else begin
                    noise.opcode       = 1'($urandom_range(1));
                    noise.pending_mask = pick_mask();
                    noise.elapsed      = pick_elapsed();
                    send_request(noise);
                    made++;
                end
                // occasional hold-off until the pipeline is empty
                if ($urandom_range(49) == 0) wait_drained();
            end
            s_valid = 1'b0;
            wait_drained();
        end

        s_valid = 1'b0;
        wait_drained();
        repeat (30) @(posedge aclk);
        if (ledger.awaiting.size() != 0) begin
            $error("%0d responses never arrived", ledger.awaiting.size());
            ledger.err_count++;
        end

        $display("Sent %0d requests over four handshake phases with random stalls.",
                 req_total);
        $display("Outcomes: %0d granted, %0d all empty, %0d charged, %0d ignored, %0d busy.",
                 ledger.status_seen[fsba_pkg::ST_GRANTED],
                 ledger.status_seen[fsba_pkg::ST_ALL_EMPTY],
                 ledger.status_seen[fsba_pkg::ST_END_CHARGED],
                 ledger.status_seen[fsba_pkg::ST_END_IGNORED],
                 ledger.status_seen[fsba_pkg::ST_BEGIN_BUSY]);
        if (ledger.err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
src/fsba_pkg.sv
src/fair_share_bucket_arbiter.sv
sim/tb_top.sv
